>>> rtl/assert_macros.svh
// Assertion macros for use in the RTL files.
// Each macro takes a label, the clock, the active-low reset, the checked
// expressions and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// When the trigger holds, the consequence holds at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

>>> rtl/shs_pkg.sv
package shs_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam int ROUNDS      = 64;
    localparam int HASH_WORDS  = 8;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    typedef logic [31:0] t_word;
    typedef logic [HASH_WORDS-1:0][31:0] t_hash;

    // Controls of the message schedule window.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [7:0] data;
    } t_sch_ctl;

    // Controls of the round unit and the chaining words.
    typedef struct packed {
        logic restart;
        logic init;
        logic step;
        logic fold;
    } t_rnd_ctl;

    // Initial hash values, element 0 is H0.
    localparam t_hash H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants.
    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Round function sigma on the a word.
    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Round function sigma on the e word.
    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Schedule sigma on the word fifteen back.
    function automatic t_word sml_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Schedule sigma on the word two back.
    function automatic t_word sml_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> rtl/shs_sched.sv
module shs_sched (
    input  logic              i_clk,
    input  shs_pkg::t_sch_ctl i_ctl,
    output shs_pkg::t_word    o_word
);
    import shs_pkg::*;

    localparam int WIN_W = BLOCK_BYTES * 8;

    // Sixteen-word window; the oldest word sits in the top bits.
    logic [WIN_W-1:0] r_win;
    t_word            n_word;

    function automatic t_word win_word(input logic [WIN_W-1:0] win, input int j);
        return win[WIN_W-1-32*j -: 32];
    endfunction

    // Next schedule word from the words sixteen, fifteen, seven and two back.
    assign n_word = win_word(r_win, 0) + sml_sig0(win_word(r_win, 1)) +
                    win_word(r_win, 9) + sml_sig1(win_word(r_win, 14));

    // Bytes shift in during loading; words shift in during the rounds.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_win <= {r_win[WIN_W-9:0], i_ctl.data};
        end else if (i_ctl.step) begin
            r_win <= {r_win[WIN_W-33:0], n_word};
        end
    end

    assign o_word = win_word(r_win, 0);

endmodule

>>> rtl/shs_round.sv
module shs_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_rnd_ctl i_ctl,
    input  shs_pkg::t_word    i_k,
    input  shs_pkg::t_word    i_w,
    output shs_pkg::t_hash    o_chain
);
    import shs_pkg::*;

    // Working variables a..h in elements 0..7.
    t_hash r_vars;
    t_hash n_vars;
    t_hash r_chain;
    t_hash n_chain;
    t_word w_t1;
    t_word w_t2;
    t_word w_ch;
    t_word w_maj;

    // One compression round.
    always_comb begin
        w_ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
        w_maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^
                (r_vars[1] & r_vars[2]);
        w_t1  = r_vars[7] + big_sig1(r_vars[4]) + w_ch + i_k + i_w;
        w_t2  = big_sig0(r_vars[0]) + w_maj;
        n_vars    = r_vars;
        n_vars[0] = w_t1 + w_t2;
        n_vars[1] = r_vars[0];
        n_vars[2] = r_vars[1];
        n_vars[3] = r_vars[2];
        n_vars[4] = r_vars[3] + w_t1;
        n_vars[5] = r_vars[4];
        n_vars[6] = r_vars[5];
        n_vars[7] = r_vars[6];
    end

    // Feed-forward of the working variables into the chaining words.
    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            n_chain[i] = r_chain[i] + r_vars[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_vars <= r_chain;
        end else if (i_ctl.step) begin
            r_vars <= n_vars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= H_INIT;
        end else if (i_ctl.restart) begin
            r_chain <= H_INIT;
        end else if (i_ctl.fold) begin
            r_chain <= n_chain;
        end
    end

    assign o_chain = r_chain;

endmodule

>>> rtl/sha256_stream_hasher.sv
// Input bytes are taken at one per cycle while the block buffer fills.
// Each full 64-byte block then runs 64 rounds on one shared round unit plus
// one fold step, taking no input meanwhile. Closing a message pads one byte
// per cycle up to the block end, compresses one or two blocks, then sends
// eight digest words at one per cycle while the receiver is ready.
// Reset loads the initial hash values and clears the fill and length counters.
`include "assert_macros.svh"

module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_data
    input  logic        i_s_axis_tuser,   // [0] byte_valid
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        o_m_axis_tlast
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_COMP,
        S_FOLD,
        S_OUT
    } t_state;

    localparam logic [6:0] FILL_FULL  = 7'(BLOCK_BYTES);
    localparam logic [6:0] FILL_LEN   = 7'(LEN_POS);
    localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
    localparam logic [2:0] WORD_LAST  = 3'(HASH_WORDS - 1);

    t_state      r_state,     n_state;
    logic [6:0]  r_fill,      n_fill;
    logic [60:0] r_total,     n_total;
    logic [5:0]  r_round,     n_round;
    logic [2:0]  r_widx,      n_widx;
    logic        r_pend_last, n_pend_last;
    logic        r_in_pad,    n_in_pad;
    logic        r_pad_first, n_pad_first;
    logic        r_len_ok,    n_len_ok;

    t_sch_ctl    sch_ctl;
    t_rnd_ctl    rnd_ctl;
    t_word       w_sched;
    t_hash       w_chain;
    logic        in_acc;
    logic        out_acc;
    logic [6:0]  fill_inc;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign fill_inc = r_fill + 7'd1;

    // Padding byte: the end marker, zero fill, or the big-endian bit length.
    assign bit_len  = {r_total, 3'b000};
    assign len_byte = bit_len[{~r_fill[2:0], 3'b000} +: 8];
    assign pad_byte = r_pad_first ? PAD_BYTE :
                      (r_len_ok && (r_fill >= FILL_LEN)) ? len_byte : ZERO_BYTE;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_total     = r_total;
        n_round     = r_round;
        n_widx      = r_widx;
        n_pend_last = r_pend_last;
        n_in_pad    = r_in_pad;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        sch_ctl     = '0;
        rnd_ctl     = '0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (i_s_axis_tuser) begin
                        sch_ctl.load = 1'b1;
                        sch_ctl.data = i_s_axis_tdata;
                        n_total      = r_total + 61'd1;
                    end
                    if (i_s_axis_tuser && (fill_inc == FILL_FULL)) begin
                        n_fill      = '0;
                        n_round     = '0;
                        rnd_ctl.init = 1'b1;
                        n_pend_last = i_s_axis_tlast;
                        n_state     = S_COMP;
                    end else begin
                        if (i_s_axis_tuser) begin
                            n_fill = fill_inc;
                        end
                        if (i_s_axis_tlast) begin
                            n_state     = S_PAD;
                            n_in_pad    = 1'b1;
                            n_pad_first = 1'b1;
                            n_len_ok    = 1'b0;
                        end
                    end
                end
            end
            S_PAD: begin
                sch_ctl.load = 1'b1;
                sch_ctl.data = pad_byte;
                n_pad_first  = 1'b0;
                // Room for the length in this block after the end marker.
                if (r_pad_first && (r_fill < FILL_LEN)) begin
                    n_len_ok = 1'b1;
                end
                if (fill_inc == FILL_FULL) begin
                    n_fill       = '0;
                    n_round      = '0;
                    rnd_ctl.init = 1'b1;
                    n_state      = S_COMP;
                end else begin
                    n_fill = fill_inc;
                end
            end
            S_COMP: begin
                sch_ctl.step = 1'b1;
                rnd_ctl.step = 1'b1;
                n_round      = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                rnd_ctl.fold = 1'b1;
                if (r_in_pad) begin
                    if (r_len_ok) begin
                        n_widx  = '0;
                        n_state = S_OUT;
                    end else begin
                        // The marker block had no room; the length goes in the next one.
                        n_len_ok = 1'b1;
                        n_state  = S_PAD;
                    end
                end else if (r_pend_last) begin
                    n_pend_last = 1'b0;
                    n_in_pad    = 1'b1;
                    n_pad_first = 1'b1;
                    n_len_ok    = 1'b0;
                    n_state     = S_PAD;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_widx == WORD_LAST) begin
                        rnd_ctl.restart = 1'b1;
                        n_total  = '0;
                        n_fill   = '0;
                        n_in_pad = 1'b0;
                        n_len_ok = 1'b0;
                        n_state  = S_LOAD;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_total     <= '0;
            r_round     <= '0;
            r_widx      <= '0;
            r_pend_last <= 1'b0;
            r_in_pad    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_round     <= n_round;
            r_widx      <= n_widx;
            r_pend_last <= n_pend_last;
            r_in_pad    <= n_in_pad;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
        end
    end

    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sch_ctl),
        .o_word(w_sched)
    );

    shs_round u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (rnd_ctl),
        .i_k    (K_TABLE[r_round]),
        .i_w    (w_sched),
        .o_chain(w_chain)
    );

    // Digest words come straight from the chaining registers.
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {5'b00000, r_widx, w_chain[r_widx]};
    assign o_m_axis_tlast  = (r_widx == WORD_LAST);

    `ASSERT_ALWAYS(a_one_side, i_clk, i_rst_n, !(o_s_axis_tready && o_m_axis_tvalid), "input and output both open")
    `ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill[6] == 1'b0, "fill count reached a full block")
    `ASSERT_NEXT(a_round_end, i_clk, i_rst_n, (r_state == S_COMP) && (r_round == ROUND_LAST), r_state == S_FOLD, "rounds did not end in fold")
    `ASSERT_NEXT(a_restart, i_clk, i_rst_n, out_acc && o_m_axis_tlast, o_s_axis_tready && (r_fill == '0) && (r_total == '0), "no clean restart after digest")

endmodule

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the hasher. It predicts the digest of
// every closed message and compares each returned word with the oldest
// word still owed.
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_data
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Digest words that the block still owes, oldest first.
    t_digest_word digest_queue[$];

    // Model copy of the hashing state.
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [6:0]  fill;
    logic [60:0] msg_bytes;
    int          error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = digest_queue.size();

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV_WORDS[i];
        fill      = '0;
        msg_bytes = '0;
    endfunction

    // One compression of the buffered 64 bytes into the chaining words.
    function automatic void absorb_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (t = 0; t < 64; t++) begin
            s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t];
            s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e;
            e = d + t1;
            d = c; c = b; b = a;
            a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    // Pad the message, compress what is left and queue the eight digest words.
    function automatic void finish_message();
        logic [63:0]  bit_len;
        t_digest_word entry;
        int pos;
        int s;
        bit_len = {msg_bytes, 3'b000};
        pos = fill;
        msg_block[pos] = 8'h80;
        pos++;
        // Not enough room for the length: pad out and use one more block.
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            absorb_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (s = 7; s >= 0; s--) begin
            msg_block[pos] = bit_len[8*s +: 8];
            pos++;
        end
        absorb_block();
        for (int i = 0; i < 8; i++) begin
            entry.word  = hash_state[i];
            entry.index = 3'(i);
            entry.last  = (i == 7);
            digest_queue.push_back(entry);
        end
        restart_message();
    endfunction

    // Apply one accepted request to the model.
    function automatic void take_request(input logic [7:0] data, input logic valid,
                                         input logic closing);
        if (valid) begin
            msg_block[fill] = data;
            fill++;
            msg_bytes++;
            if (fill == 7'd64) begin
                absorb_block();
                fill = '0;
            end
        end
        if (closing)
            finish_message();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Outputs are compared before inputs are applied, so a word can never be
    // matched against a digest closed at the same clock edge.
    always @(posedge i_clk) begin : monitor
        t_digest_word want;
        if (!i_rst_n) begin
            restart_message();
            digest_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("digest word with none pending", i_m_tdata[31:0], '0);
                end else begin
                    want = digest_queue.pop_front();
                    if (i_m_tdata[31:0] !== want.word)
                        report_mismatch("digest_word", i_m_tdata[31:0], want.word);
                    if (i_m_tdata[34:32] !== want.index)
                        report_mismatch("word_index", 32'(i_m_tdata[34:32]), 32'(want.index));
                    if (i_m_tlast !== want.last)
                        report_mismatch("last_word", 32'(i_m_tlast), 32'(want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_request(i_s_tdata, i_s_tuser, i_s_tlast);
        end
    end

endmodule

>>> tb/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [7:0]  s_tdata    = 8'h00;   // [7:0] byte_data
    logic        s_tuser    = 1'b0;    // [0] byte_valid
    logic        s_tlast    = 1'b0;
    logic        m_tready   = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;              // [31:0] digest_word, [34:32] word_index, zero fill
    logic        m_tlast;
    int          errors;
    int          pending;

    // While set, neither side inserts gaps.
    bit          quiet = 1'b0;
    int unsigned stall_left = 0;

    sha256_stream_hasher i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    sha256_digest_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tlast  (m_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Safety net in case the block hangs.
    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Digest side: after each accepted word the receiver may stall a while.
    always @(posedge clk) begin : digest_ready
        int unsigned gap;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tready && m_tvalid) begin
            gap = pick_gap();
            stall_left <= gap;
            m_tready   <= (gap == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one request after an optional gap and hold it until taken.
    task automatic send_item(input logic [7:0] data, input logic valid, input logic closing);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= closing;
        do @(posedge clk); while (!s_tready);
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        bit          close_on_byte;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, idle requests, a byte on the closing request
        // at both extremes, a short known message and back-to-back closes.
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);

        // Random messages; lengths cluster around the padding boundaries.
        while (sent < 470) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 10);
                5, 6, 7: len = $urandom_range(0, 1) ? $urandom_range(54, 57)
                                                    : $urandom_range(62, 65);
                8: len = $urandom_range(11, 50);
                default: len = $urandom_range(100, 130);
            endcase
            close_on_byte = (len != 0) && $urandom_range(0, 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                    sent++;
                end
                send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
                sent++;
            end
            if (!close_on_byte) begin
                send_item(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain the outstanding digest words, then allow a short tail.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_sched.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_tb.sv
